[src/pts_pkg.sv]
`default_nettype none

package pts_pkg;

  // Number of task slots in the table.
  localparam int unsigned TaskSlots = 8;
  // Slot index width and task count width (count reaches TaskSlots itself).
  localparam int unsigned IdxW = 3;
  localparam int unsigned CntW = 4;
  localparam int unsigned PrioW = 8;
  localparam int unsigned SleepW = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [PrioW-1:0] prio_t;
  typedef logic [SleepW-1:0] sleep_t;

  typedef enum logic [1:0] {
    OpCreate   = 2'd0,
    OpDelay    = 2'd1,
    OpTick     = 2'd2,
    OpSchedule = 2'd3
  } op_e;

endpackage

`default_nettype wire

[src/pts_if.sv]
`default_nettype none

// Request channel: one scheduler operation per transfer.
interface pts_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  pts_pkg::prio_t       task_priority;
  pts_pkg::sleep_t      delay_ticks;

  modport source (output valid, opcode, task_priority, delay_ticks, input ready);
  modport sink   (input valid, opcode, task_priority, delay_ticks, output ready);
endinterface

// Response channel: one result per request.
interface pts_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  pts_pkg::idx_t        current_task;
  logic                 switch_request;
  pts_pkg::cnt_t        task_total;

  modport source (output valid, accepted, current_task, switch_request, task_total,
                  input ready);
  modport sink   (input valid, accepted, current_task, switch_request, task_total,
                  output ready);
endinterface

`default_nettype wire

[src/priority_task_scheduler.sv]
// Channel   Dir  Payload                                                  Width
// -------   ---  -------------------------------------------------------  -----
// in_i      in   opcode, task_priority, delay_ticks                       2+8+32
// out_o     out  accepted, current_task, switch_request, task_total       1+3+1+4
//
// Create and delay are settled in the cycle of the request transfer; the result is
// then loaded into the output register from the result state. Tick and schedule walk
// the slot table with one shared decrement/compare unit, one created slot per cycle,
// and then move to the result state. The request side is ready only while the
// sequencer is idle. A stalled output holds its result and the sequencer waits in its
// result state until the output register is free.
// Reset clears the sleep counters, the task count and the running index at once.
`default_nettype none

module priority_task_scheduler (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pts_req_if.sink     in_i,
  pts_rsp_if.source   out_o
);

  // One-hot sequencer: idle, tick walk, schedule walk, result hand-off.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StTick   = 4'b0010,
    StSched  = 4'b0100,
    StResult = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Slot table. Priority and ready flags are only read for created slots, so
  // they carry no reset. Sleep counters reset to zero.
  pts_pkg::prio_t  prio_q  [pts_pkg::TaskSlots];
  logic            ready_q [pts_pkg::TaskSlots];
  pts_pkg::sleep_t sleep_q [pts_pkg::TaskSlots];

  pts_pkg::cnt_t   count_q, count_d;
  pts_pkg::idx_t   run_idx_q, run_idx_d;
  // Copy of the running task's priority, so the table is read at one index only.
  pts_pkg::prio_t  run_prio_q;

  // Walk state.
  pts_pkg::idx_t   idx_q, idx_d;
  logic            found_q;
  pts_pkg::idx_t   best_idx_q;
  pts_pkg::prio_t  best_prio_q;

  // Result being assembled.
  logic            acc_q;
  logic            sw_q;

  // Output register.
  logic            out_valid_q;
  logic            out_acc_q;
  pts_pkg::idx_t   out_task_q;
  logic            out_sw_q;
  pts_pkg::cnt_t   out_total_q;

  logic            in_xfer;
  pts_pkg::op_e    op;
  logic            has_task;
  logic            table_full;
  logic            create_ok;
  logic            delay_ok;
  pts_pkg::prio_t  cur_prio;
  pts_pkg::sleep_t cur_sleep;
  logic            last_slot;
  logic            wake;
  logic            take;
  logic            out_load;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign op         = pts_pkg::op_e'(in_i.opcode);
  assign has_task   = (count_q != '0);
  assign table_full = (count_q >= pts_pkg::CntW'(pts_pkg::TaskSlots));
  assign create_ok  = in_xfer && (op == pts_pkg::OpCreate) && !table_full;
  assign delay_ok   = in_xfer && (op == pts_pkg::OpDelay) && has_task;

  // Shared walk unit: one slot per cycle.
  assign cur_prio  = prio_q[idx_q];
  assign cur_sleep = sleep_q[idx_q];
  assign last_slot = ((pts_pkg::CntW'(idx_q) + pts_pkg::CntW'(1)) == count_q);
  // A sleeping slot wakes when its counter steps from one to zero.
  assign wake      = (state_q == StTick) && (cur_sleep == pts_pkg::SleepW'(1));
  // Ties go to the higher slot, hence the greater-or-equal compare.
  assign take      = (state_q == StSched) && ready_q[idx_q] &&
                     (!found_q || (cur_prio >= best_prio_q));

  assign out_load  = (state_q == StResult) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    run_idx_d = run_idx_q;
    unique case (state_q)
      StIdle: begin
        idx_d = '0;
        if (in_xfer) begin
          unique case (op)
            pts_pkg::OpCreate: begin
              state_d = StResult;
              if (create_ok) begin
                count_d = count_q + pts_pkg::CntW'(1);
                if (!has_task) begin
                  run_idx_d = '0;
                end
              end
            end
            pts_pkg::OpDelay: state_d = StResult;
            pts_pkg::OpTick: state_d = has_task ? StTick : StResult;
            pts_pkg::OpSchedule: state_d = has_task ? StSched : StResult;
            default: state_d = StResult;
          endcase
        end
      end
      StTick: begin
        idx_d = idx_q + pts_pkg::IdxW'(1);
        if (last_slot) begin
          state_d = StResult;
        end
      end
      StSched: begin
        idx_d = idx_q + pts_pkg::IdxW'(1);
        if (last_slot) begin
          state_d = StResult;
          if (take) begin
            run_idx_d = idx_q;
          end else if (found_q) begin
            run_idx_d = best_idx_q;
          end
        end
      end
      StResult: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      count_q     <= '0;
      run_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      run_idx_q <= run_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sleep counters: written by delay at the running slot, stepped down by the walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pts_pkg::TaskSlots; i++) begin
        sleep_q[i] <= '0;
      end
    end else if (delay_ok) begin
      sleep_q[run_idx_q] <= in_i.delay_ticks;
    end else if ((state_q == StTick) && (cur_sleep != '0)) begin
      sleep_q[idx_q] <= cur_sleep - pts_pkg::SleepW'(1);
    end
  end

  // Table contents and walk payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (create_ok) begin
      prio_q[count_q[pts_pkg::IdxW-1:0]]  <= in_i.task_priority;
      ready_q[count_q[pts_pkg::IdxW-1:0]] <= 1'b1;
      if (!has_task) begin
        run_prio_q <= in_i.task_priority;
      end
    end else if (delay_ok) begin
      ready_q[run_idx_q] <= 1'b0;
    end else if (wake) begin
      ready_q[idx_q] <= 1'b1;
    end

    if (in_xfer) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_prio_q <= '0;
      sw_q        <= delay_ok;
      unique case (op)
        pts_pkg::OpCreate: acc_q <= !table_full;
        pts_pkg::OpDelay:  acc_q <= has_task;
        default:           acc_q <= 1'b1;
      endcase
    end else begin
      if (take) begin
        found_q     <= 1'b1;
        best_idx_q  <= idx_q;
        best_prio_q <= cur_prio;
      end
      if (wake && (cur_prio > run_prio_q)) begin
        sw_q <= 1'b1;
      end
      if ((state_q == StSched) && last_slot) begin
        if (take) begin
          run_prio_q <= cur_prio;
        end else if (found_q) begin
          run_prio_q <= best_prio_q;
        end
      end
    end

    if (out_load) begin
      out_acc_q   <= acc_q;
      out_task_q  <= run_idx_q;
      out_sw_q    <= sw_q;
      out_total_q <= count_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.accepted       = out_acc_q;
  assign out_o.current_task   = out_task_q;
  assign out_o.switch_request = out_sw_q;
  assign out_o.task_total     = out_total_q;

endmodule

`default_nettype wire

[src/pts_checker.sv]
`default_nettype none

module pts_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_i,
  input wire logic          out_valid_i,
  input wire logic          out_ready_i,
  input wire logic          accepted_i,
  input wire pts_pkg::idx_t current_task_i,
  input wire logic          switch_request_i,
  input wire pts_pkg::cnt_t task_total_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({accepted_i, current_task_i, switch_request_i, task_total_i}))
    else $error("result changed while stalled");

  // The running task is always one of the created ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (task_total_i != '0) |->
      (pts_pkg::cnt_t'(current_task_i) < task_total_i) &&
      (task_total_i <= pts_pkg::cnt_t'(pts_pkg::TaskSlots)))
    else $error("running task outside the created range");

  // A switch is only requested by an operation that was applied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && switch_request_i |-> accepted_i)
    else $error("switch request on a refused operation");

  // The block is not ready in the cycle after taking a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .accepted_i       (out_o.accepted),
  .current_task_i   (out_o.current_task),
  .switch_request_i (out_o.switch_request),
  .task_total_i     (out_o.task_total)
);

`default_nettype wire
